// ===== sv/kmp_prefix_function_macros.svh =====
// ---------------------------------------------------------------------------
// kmp prefix function assertion macros
// shared concurrent assertion forms for the block's rtl
// ---------------------------------------------------------------------------
`ifndef KMP_PREFIX_FUNCTION_MACROS_SVH
`define KMP_PREFIX_FUNCTION_MACROS_SVH

// same-cycle implication
`define KMP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KMP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/kmp_pf_pkg.sv =====
// ---------------------------------------------------------------------------
// kmp prefix function package
// item types shared by the prefix function rtl
// ---------------------------------------------------------------------------
package kmp_pf_pkg;

   localparam int CHAR_W = 8;
   localparam int FIELD_W = 8;

   typedef struct packed {
      logic              first;
      logic [CHAR_W-1:0] pattern_char;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] prefix_length;
      logic               overflow;
   } rsp_type;

endpackage

// ===== sv/kmp_pf_ram.sv =====
// ---------------------------------------------------------------------------
// kmp prefix function ram
// simple dual port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module kmp_pf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kmp_prefix_function.sv =====
// ---------------------------------------------------------------------------
// kmp prefix function
// computes the kmp border length for each pattern character as it arrives
// ---------------------------------------------------------------------------
// usage:
//   an item (first flag, pattern byte) is taken when start is high and busy
//   is low. first restarts the pattern at position zero.
//   each item gives one result on rsp_data, marked by rsp_strobe for one
//   cycle, in the cycle after the sequencer finishes. the receiver cannot
//   stall; results must be taken when strobed.
//   position zero and overflow items are answered straight from idle, with
//   busy left low; other items pass through fetch and then compare, which
//   repeats once per fallback step, and the next item is taken once the
//   sequencer is back in idle. fallback steps average at most one per character.
//   busy is high while an item walks the border chain.
//   characters past MAX_PATTERN_LEN give position 0, prefix 0, overflow 1
//   until the next first flag.
//   reset clears the position counter and sequencer; the memories are not
//   cleared, since only entries of the current pattern are ever read.
// ---------------------------------------------------------------------------
`include "kmp_prefix_function_macros.svh"

module kmp_prefix_function
   import kmp_pf_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_PATTERN_LEN);
   localparam int POS_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PATTERN_LEN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CMP
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   next_pos_ff, next_pos_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   len_ff, len_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [POS_W-1:0]   req_pos;
   logic               req_over;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [CHAR_W-1:0]  wr_char;
   logic [IDX_W-1:0]   wr_border;
   logic [IDX_W-1:0]   border_rd_addr;
   logic [IDX_W-1:0]   border_rd_data;
   logic [CHAR_W-1:0]  char_rd_data;
   logic               char_match;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_pos  = req_data.first ? '0 : next_pos_ff;
   assign req_over = (req_pos >= POS_MAX);

   // shared compare against the character at the current border length
   assign char_match = (char_rd_data == char_ff);

   assign border_rd_addr = (state_ff == ST_IDLE) ? (req_pos[IDX_W-1:0] - 1'b1)
                                                 : (border_rd_data - 1'b1);

   kmp_pf_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_PATTERN_LEN)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (border_rd_data),
      .rd_data (char_rd_data)
   );

   kmp_pf_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_PATTERN_LEN)
   ) u_border_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_border),
      .rd_addr (border_rd_addr),
      .rd_data (border_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      next_pos_in   = next_pos_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      char_in       = char_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_char       = char_ff;
      wr_border     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in = req_data.pattern_char;
               pos_in  = req_pos[IDX_W-1:0];
               if (req_over) begin
                  next_pos_in   = POS_MAX;
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{position: '0, prefix_length: '0, overflow: 1'b1};
               end else if (req_pos == '0) begin
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  wr_char       = req_data.pattern_char;
                  next_pos_in   = POS_W'(1);
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{position: '0, prefix_length: '0, overflow: 1'b0};
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            len_in   = border_rd_data;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (char_match || (len_ff == '0)) begin
               wr_en         = 1'b1;
               wr_border     = char_match ? (len_ff + 1'b1) : '0;
               next_pos_in   = POS_W'(pos_ff) + 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{position: FIELD_W'(pos_ff),
                                 prefix_length: FIELD_W'(wr_border),
                                 overflow: 1'b0};
               state_in      = ST_IDLE;
            end else begin
               // fall back to the border of the shorter prefix
               len_in = border_rd_data;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_pos_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_pos_ff   <= next_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      char_ff     <= char_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `KMP_ASSERT_NXT(a_accept_progress, clock, reset, accept, busy || rsp_strobe,
                   "accepted item neither busy nor answered")
   `KMP_ASSERT_IMP(a_len_below_pos, clock, reset, state_ff == ST_CMP, len_ff < pos_ff,
                   "border length not below position")
   `KMP_ASSERT_IMP(a_next_pos_range, clock, reset, 1'b1, next_pos_ff <= POS_MAX,
                   "next position beyond capacity")
   `KMP_ASSERT_NXT(a_fetch_to_cmp, clock, reset, state_ff == ST_FETCH, state_ff == ST_CMP,
                   "fetch not followed by compare")

endmodule

// ===== sim/kmp_border_check_pkg.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmp border scoreboard
// keeps its own copy of the pattern and border values, predicts the
// position, border length and overflow flag of every accepted item, and
// compares each strobed result with the oldest prediction
// ---------------------------------------------------------------------------
package kmp_border_check_pkg;

   import kmp_pf_pkg::*;

   localparam int PATTERN_CAPACITY = 256;

   class kmp_border_scoreboard;

      logic [7:0] char_copy [PATTERN_CAPACITY];
      int border_copy [PATTERN_CAPACITY];
      int next_index;
      rsp_type expected_q [$];
      int mismatch_count;

      function new();
         next_index = 0;
         mismatch_count = 0;
      endfunction

      function void note_item(req_type item);
         int pos;
         int len;
         rsp_type want;
         if (item.first) begin
            next_index = 0;
         end
         pos = next_index;
         if (pos >= PATTERN_CAPACITY) begin
            next_index = PATTERN_CAPACITY;
            want.position = '0;
            want.prefix_length = '0;
            want.overflow = 1'b1;
         end else begin
            len = 0;
            if (pos > 0) begin
               len = border_copy[pos - 1];
               while (len > 0 && item.pattern_char != char_copy[len]) begin
                  len = border_copy[len - 1];
               end
               if (item.pattern_char == char_copy[len]) begin
                  len++;
               end
            end
            char_copy[pos] = item.pattern_char;
            border_copy[pos] = len;
            next_index = pos + 1;
            want.position = pos[7:0];
            want.prefix_length = len[7:0];
            want.overflow = 1'b0;
         end
         expected_q.insert(expected_q.size(), want);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result pos %0d len %0d ovf %0b",
               got.position, got.prefix_length, got.overflow));
            return;
         end
         want = expected_q.pop_front();
         if (got.position !== want.position) begin
            report_mismatch($sformatf("position %0d, want %0d",
               got.position, want.position));
         end
         if (got.prefix_length !== want.prefix_length) begin
            report_mismatch($sformatf("prefix_length %0d, want %0d at position %0d",
               got.prefix_length, want.prefix_length, want.position));
         end
         if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %0b, want %0b at position %0d",
               got.overflow, want.overflow, want.position));
         end
      endtask

   endclass

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmp prefix function testbench
// feeds directed and random patterns (random bytes, two-symbol and
// repeating motifs, over-long patterns, missing and stray first flags)
// with random gaps, and checks every result against a scoreboard
// ---------------------------------------------------------------------------
module testbench;

   import kmp_pf_pkg::*;
   import kmp_border_check_pkg::*;

   localparam int ITEM_TARGET = 1150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   kmp_border_scoreboard border_sb;
   int sent_count = 0;
   int burst_left = 0;
   bit quiet_burst = 1'b0;

   req_type directed_items [$] = '{
      {1'b0, 8'hA5}, {1'b0, 8'hA5},
      {1'b1, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h00},
      {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'hFE},
      {1'b1, 8'hFF},
      {1'b1, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h7F}, {1'b0, 8'h80},
      {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80},
      {1'b1, 8'h01}, {1'b1, 8'h01}
   };

   always #4 clock = ~clock;

   kmp_prefix_function #(
      .MAX_PATTERN_LEN(PATTERN_CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         border_sb.check_result(rsp_data);
      end
   end

   task automatic send_item(req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(10, 60);
         quiet_burst = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      gap = quiet_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      border_sb.note_item(item);
      sent_count++;
   endtask

   task automatic send_pattern(int len, bit lead_first, bit noisy_first);
      int mode;
      int period;
      logic [7:0] sym_a;
      logic [7:0] sym_b;
      logic [7:0] motif [6];
      req_type item;
      mode = $urandom_range(0, 3);
      sym_a = 8'($urandom_range(0, 255));
      sym_b = 8'($urandom_range(0, 255));
      period = $urandom_range(1, 6);
      for (int k = 0; k < 6; k++) begin
         motif[k] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: item.pattern_char = 8'($urandom_range(0, 255));
            1: item.pattern_char = $urandom_range(0, 1) ? sym_a : sym_b;
            2: item.pattern_char = ($urandom_range(0, 9) == 0) ? sym_b : sym_a;
            default: item.pattern_char = ($urandom_range(0, 7) == 0) ? sym_b : motif[i % period];
         endcase
         if (i == 0) begin
            item.first = lead_first;
         end else begin
            item.first = noisy_first && ($urandom_range(0, 15) == 0);
         end
         send_item(item);
      end
   endtask

   initial begin
      int pattern_count;
      int len;
      border_sb = new();
      pattern_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_items[i]) begin
         send_item(directed_items[i]);
      end
      while (sent_count < ITEM_TARGET) begin
         // an occasional over-long pattern runs into the overflow region
         if (pattern_count == 2 || $urandom_range(0, 29) == 0) begin
            len = $urandom_range(257, 290);
         end else begin
            len = $urandom_range(1, 48);
         end
         send_pattern(len, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
         pattern_count++;
      end
      start <= 1'b0;
      while (border_sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (border_sb.mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== kmp_prefix_function.f =====
+incdir+sv
sv/kmp_pf_pkg.sv
sv/kmp_pf_ram.sv
sv/kmp_prefix_function.sv
sim/kmp_border_check_pkg.sv
sim/testbench.sv
